@@ design/assert_macros.svh @@
// Assertion macros shared by the checker files.
// Each macro expects signals named clk and arst_n in the scope of its use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/sstf_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Freshness table package
// Field widths, verdict codes and the command and status bundles that
// connect the controller with the datapath.
// ---------------------------------------------------------------------------
package sstf_pkg;

	localparam int MAC_W = 48;
	localparam int SEQ_W = 16;
	localparam int VERDICT_W = 2;
	localparam int TABLE_ENTRIES_DEF = 64;
	localparam int WRAP_LIMIT = 1 << 15;

	typedef enum logic [VERDICT_W-1:0] {
		VERDICT_STALE = 2'd0,
		VERDICT_NEWER = 2'd1,
		VERDICT_FULL  = 2'd2
	} verdict_t;

	// Controller to datapath.
	typedef struct packed {
		logic start;   // latch the key and restart the scan
		logic step;    // advance the scan by one entry
		logic commit;  // apply the decision and load the result register
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic used_zero;  // table holds no entries
		logic match;      // entry under compare holds the key
		logic miss_done;  // every entry compared, none matched
	} dp_status_t;

endpackage

@@ design/sstf_req_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying a source address and a sequence number.
// ---------------------------------------------------------------------------
interface sstf_req_if;
	import sstf_pkg::*;

	logic             valid;
	logic             ready;
	logic [MAC_W-1:0] source_mac;
	logic [SEQ_W-1:0] seq_num;

	modport source (output valid, output source_mac, output seq_num, input ready);
	modport sink   (input valid, input source_mac, input seq_num, output ready);
endinterface

@@ design/sstf_rsp_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the verdict for one request.
// ---------------------------------------------------------------------------
interface sstf_rsp_if;
	import sstf_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [VERDICT_W-1:0] verdict;
	logic                 new_source;

	modport source (output valid, output verdict, output new_source, input ready);
	modport sink   (input valid, input verdict, input new_source, output ready);
endinterface

@@ design/sstf_datapath.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Freshness table datapath
// Table memory, scan counters, key compare, sequence decision and the
// result register.
// ---------------------------------------------------------------------------
module sstf_datapath #(
	parameter int TABLE_ENTRIES = sstf_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  sstf_pkg::dp_cmd_t              cmd,
	output sstf_pkg::dp_status_t           status,
	input  logic [sstf_pkg::MAC_W-1:0]     source_mac,
	input  logic [sstf_pkg::SEQ_W-1:0]     seq_num,
	output logic [sstf_pkg::VERDICT_W-1:0] verdict,
	output logic                           new_source
);
	import sstf_pkg::*;

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);

	logic [MAC_W-1:0] mem_mac [TABLE_ENTRIES];
	logic [SEQ_W-1:0] mem_seq [TABLE_ENTRIES];

	logic [MAC_W-1:0] key_mac_q;
	logic [SEQ_W-1:0] key_seq_q;
	logic [MAC_W-1:0] rd_mac_q;
	logic [SEQ_W-1:0] rd_seq_q;
	logic [CW-1:0]    used_q;
	logic [CW-1:0]    iss_q;
	logic             cmp_v_q;
	logic [AW-1:0]    cmp_addr_q;
	logic [AW-1:0]    hit_q;
	logic             found_q;
	verdict_t         verdict_q;
	logic             new_src_q;

	logic             match;
	logic             scan_end;
	logic             full;
	logic             newer;
	logic             rd_en;
	logic             mac_we;
	logic             seq_we;
	logic [AW-1:0]    wr_addr;
	verdict_t         verdict_d;
	logic             new_src_d;

	assign match    = cmp_v_q && (rd_mac_q == key_mac_q);
	assign scan_end = (iss_q == used_q);
	assign full     = (used_q == CW'(TABLE_ENTRIES));
	assign rd_en    = cmd.step && !match && !scan_end;

	// Newer when ahead, or when behind by more than half the number space.
	assign newer = (rd_seq_q < key_seq_q) ||
		((rd_seq_q > key_seq_q) && ((rd_seq_q - key_seq_q) > SEQ_W'(WRAP_LIMIT)));

	assign status.used_zero = (used_q == '0);
	assign status.match     = match;
	assign status.miss_done = cmp_v_q && !match && scan_end;

	always_comb begin
		mac_we    = 1'b0;
		seq_we    = 1'b0;
		wr_addr   = hit_q;
		verdict_d = VERDICT_STALE;
		new_src_d = 1'b0;
		if (found_q) begin
			if (newer) begin
				seq_we    = cmd.commit;
				verdict_d = VERDICT_NEWER;
			end
		end else if (full) begin
			verdict_d = VERDICT_FULL;
		end else begin
			mac_we    = cmd.commit;
			seq_we    = cmd.commit;
			wr_addr   = used_q[AW-1:0];
			verdict_d = VERDICT_NEWER;
			new_src_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= '0;
			iss_q   <= '0;
			cmp_v_q <= 1'b0;
			found_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				iss_q   <= '0;
				cmp_v_q <= 1'b0;
				found_q <= 1'b0;
			end else if (cmd.step) begin
				if (match) begin
					found_q <= 1'b1;
					cmp_v_q <= 1'b0;
				end else if (!scan_end) begin
					iss_q   <= iss_q + CW'(1);
					cmp_v_q <= 1'b1;
				end else begin
					cmp_v_q <= 1'b0;
				end
			end
			if (mac_we) begin
				used_q <= used_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			key_mac_q <= source_mac;
			key_seq_q <= seq_num;
		end
		if (rd_en) begin
			cmp_addr_q <= iss_q[AW-1:0];
		end
		if (cmd.step && match) begin
			hit_q <= cmp_addr_q;
		end
		if (cmd.commit) begin
			verdict_q <= verdict_d;
			new_src_q <= new_src_d;
		end
	end

	// Table memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mac_we) begin
			mem_mac[wr_addr] <= key_mac_q;
		end
		if (rd_en) begin
			rd_mac_q <= mem_mac[iss_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (seq_we) begin
			mem_seq[wr_addr] <= key_seq_q;
		end
		if (rd_en) begin
			rd_seq_q <= mem_seq[iss_q[AW-1:0]];
		end
	end

	assign verdict    = verdict_q;
	assign new_source = new_src_q;
endmodule

@@ design/sstf_ctrl.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Freshness table controller
// Sequences accept, table scan and decision, and owns the result valid.
// ---------------------------------------------------------------------------
module sstf_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  sstf_pkg::dp_status_t status,
	output sstf_pkg::dp_cmd_t    cmd
);
	import sstf_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_DECIDE = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d    = state_q;
		cmd.start  = 1'b0;
		cmd.step   = 1'b0;
		cmd.commit = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = status.used_zero ? ST_DECIDE : ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.step = 1'b1;
				if (status.match || status.miss_done) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
endmodule

@@ design/source_sequence_freshness_table_core.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Source sequence freshness table
// Per-source duplicate filter: tracks the last accepted sequence number of
// each known source address and classifies every request as newer, stale
// or table full.
//
//   Channel   Role   Payload
//   request   sink   source_mac[47:0], seq_num[15:0]
//   result    source verdict[1:0], new_source
//
// A request that misses compares every occupied entry before the next ready,
// and a request to an empty table skips the scan; a hit at index k ends the
// scan once entry k is compared. The single read port of the table memory
// sets the scan rate: the scan compares one stored address per cycle.
// Reset clears the fill count and the control state; no clearing pass runs,
// since slots fill in order and only slots below the fill count are read.
// A stalled result holds in its register; the next request is accepted while
// it waits, and its own decision waits until the register is free.
// ---------------------------------------------------------------------------
module source_sequence_freshness_table_core #(
	parameter int TABLE_ENTRIES = sstf_pkg::TABLE_ENTRIES_DEF
) (
	input logic  clk,
	input logic  arst_n,
	sstf_req_if.sink   request,
	sstf_rsp_if.source result
);
	import sstf_pkg::*;

	// Command and status bundles between the controller and the datapath.
	dp_cmd_t    cmd;
	dp_status_t status;

	// The controller walks idle, scan and decide. It raises ready only in
	// idle, so at most one request is scanned or decided at a time.
	sstf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (request.valid),
		.in_ready  (request.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// The datapath holds the table memory, the fill count, the scan pointer
	// and the result register. Sources are never removed, so a stored
	// address appears at most once and the first match is the only one.
	sstf_datapath #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.source_mac (request.source_mac),
		.seq_num    (request.seq_num),
		.verdict    (result.verdict),
		.new_source (result.new_source)
	);
endmodule

@@ design/sstf_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Freshness table port checker
// Watches the top-level ports for handshake and result consistency.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sstf_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [sstf_pkg::VERDICT_W-1:0] verdict,
	input logic                           new_source
);
	import sstf_pkg::*;

	logic new_valid;

	assign new_valid = out_valid && new_source;

	// A result that is offered stays offered until it is taken.
	`ASSERT_NEXT_CYCLE(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")

	// Only one request is in flight: ready drops right after an accept.
	`ASSERT_NEXT_CYCLE(a_one_in_flight, in_valid && in_ready, !in_ready, "back-to-back accept")

	// The unused verdict code never appears.
	`ASSERT_SAME_CYCLE(a_verdict_code, out_valid, verdict <= VERDICT_FULL, "bad verdict code")

	// An inserted source is always reported as newer.
	`ASSERT_SAME_CYCLE(a_new_is_newer, new_valid, verdict == VERDICT_NEWER, "new source not newer")
endmodule

bind source_sequence_freshness_table_core sstf_checker u_sstf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (request.valid),
	.in_ready   (request.ready),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.verdict    (result.verdict),
	.new_source (result.new_source)
);

@@ tb/source_sequence_freshness_table_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Freshness table checker
// Watches the request and result channels and keeps its own copy of the
// source table. It works out the verdict for every accepted request and
// compares each accepted result with the oldest verdict still owed.
// ---------------------------------------------------------------------------
module source_sequence_freshness_table_checker #(
	parameter int TABLE_ENTRIES = sstf_pkg::TABLE_ENTRIES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	sstf_req_if  req,
	sstf_rsp_if  rsp,
	output int   failures,
	output int   outstanding
);
	import sstf_pkg::*;

	typedef struct packed {
		verdict_t verdict;
		logic     new_source;
	} verdict_rec_t;

	// Shadow table. Slots fill in order, so a slot below the fill count is valid.
	logic [MAC_W-1:0] slot_mac [TABLE_ENTRIES];
	logic [SEQ_W-1:0] slot_seq [TABLE_ENTRIES];
	int               fill_count;
	verdict_rec_t     owed_verdicts [$];
	int               fail_count = 0;

	// Classifies one packet and applies its effect on the shadow table.
	function automatic verdict_rec_t classify_packet(logic [MAC_W-1:0] mac,
			logic [SEQ_W-1:0] seq);
		verdict_rec_t rec;
		int slot;
		int seq_gap;
		slot = -1;
		rec.new_source = 1'b0;
		for (int i = 0; i < fill_count; i++)
			if (slot < 0 && slot_mac[i] == mac)
				slot = i;
		if (slot < 0) begin
			if (fill_count >= TABLE_ENTRIES) begin
				rec.verdict = VERDICT_FULL;
			end else begin
				slot_mac[fill_count] = mac;
				slot_seq[fill_count] = seq;
				fill_count++;
				rec.verdict = VERDICT_NEWER;
				rec.new_source = 1'b1;
			end
		end else begin
			seq_gap = int'(slot_seq[slot]) - int'(seq);
			if (seq_gap > WRAP_LIMIT || slot_seq[slot] < seq) begin
				slot_seq[slot] = seq;
				rec.verdict = VERDICT_NEWER;
			end else begin
				rec.verdict = VERDICT_STALE;
			end
		end
		return rec;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		verdict_rec_t owed;
		if (!arst_n) begin
			fill_count = 0;
			owed_verdicts.delete();
		end else begin
			// Retire the result first: a result in the same cycle as a request
			// always belongs to an earlier request.
			if (rsp.valid && rsp.ready) begin
				if (owed_verdicts.size() == 0) begin
					$error("result accepted with no request outstanding");
					fail_count++;
				end else begin
					owed = owed_verdicts.pop_front();
					if (rsp.verdict !== owed.verdict) begin
						$error("verdict mismatch: expected %0d, actual %0d",
							owed.verdict, rsp.verdict);
						fail_count++;
					end
					if (rsp.new_source !== owed.new_source) begin
						$error("new_source mismatch: expected %0d, actual %0d",
							owed.new_source, rsp.new_source);
						fail_count++;
					end
				end
			end
			if (req.valid && req.ready)
				owed_verdicts.push_back(classify_packet(req.source_mac, req.seq_num));
		end
		failures <= fail_count;
		outstanding <= owed_verdicts.size();
	end

endmodule

@@ tb/source_sequence_freshness_table_core_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Freshness table test
// Drives directed and random requests into the freshness table, stalls both
// channels at random, and reports the verdict of the checker.
// ---------------------------------------------------------------------------
module source_sequence_freshness_table_core_test;
	import sstf_pkg::*;

	localparam int ENTRIES = TABLE_ENTRIES_DEF;
	// Slightly more hosts than slots, so the table fills and stays full.
	localparam int HOSTS = ENTRIES + 8;
	localparam int RANDOM_REQUESTS = 980;
	// The last requests run with neither side idling.
	localparam int CALM_REQUESTS = 100;
	// The limit covers the longest scan of a request plus the longest stall
	// on each side, many times over.
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 2 * ENTRIES + 16;

	logic clk;
	logic arst_n;
	bit   calm;
	int   idle_cycles;
	int   failures;
	int   outstanding;

	logic [MAC_W-1:0] host_mac [HOSTS];
	logic [SEQ_W-1:0] host_seq [HOSTS];

	sstf_req_if req_ch ();
	sstf_rsp_if rsp_ch ();

	source_sequence_freshness_table_core #(
		.TABLE_ENTRIES(ENTRIES)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.request(req_ch),
		.result (rsp_ch)
	);

	source_sequence_freshness_table_checker #(
		.TABLE_ENTRIES(ENTRIES)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.failures   (failures),
		.outstanding(outstanding)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Presents one request and holds it until the table takes it. Outside the
	// calm stretch, a random gap may come first so that idle cycles on the
	// request side land on every phase of the scan.
	task automatic send_request(input logic [MAC_W-1:0] mac, input logic [SEQ_W-1:0] seq);
		if (!calm && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.source_mac <= mac;
		req_ch.seq_num <= seq;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	// The result side holds ready high or low in random bursts and stops
	// stalling in the calm stretch at the end.
	initial begin
		rsp_ch.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (calm) begin
				rsp_ch.ready <= 1'b1;
				@(posedge clk);
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 2) != 0);
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end
		end
	end

	// The watchdog counts cycles in which neither channel moves a request
	// or a result. A hung scan or a lost result ends the run here.
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		int k;
		int pick;
		int delta;
		logic [MAC_W-1:0] mac;
		logic [SEQ_W-1:0] seq;

		calm = 1'b0;
		arst_n = 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.source_mac <= '0;
		req_ch.seq_num <= '0;
		for (int i = 0; i < HOSTS; i++) begin
			host_mac[i] = {16'($urandom()), 32'($urandom())};
			host_seq[i] = 16'($urandom());
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. The all-zero address walks through equal numbers,
		// the wrap of the sequence space and the half-range distance, which
		// must come out stale. The all-ones address does the same from the
		// other end. Then a handful of addresses that differ from the first
		// two in one bit or in alternating bits.
		send_request('0, 16'h0000);
		send_request('0, 16'h0000);
		send_request('0, 16'hFFFF);
		send_request('0, 16'h7FFF);
		send_request('0, 16'h7FFE);
		send_request('0, 16'h7FFD);
		send_request('0, 16'h7FFF);
		send_request('1, 16'hFFFF);
		send_request('1, 16'h0000);
		send_request('1, 16'h8000);
		send_request('1, 16'h0000);
		send_request('1, 16'h0001);
		send_request('1, 16'h8001);
		send_request(48'h0000_0000_0001, 16'h1234);
		send_request(48'h8000_0000_0000, 16'hFFFF);
		send_request(48'h7FFF_FFFF_FFFF, 16'h8000);
		send_request(48'hFFFF_FFFF_FFFE, 16'h0001);
		send_request(48'hAAAA_AAAA_AAAA, 16'h5555);
		send_request(48'h5555_5555_5555, 16'hAAAA);
		send_request(48'h0000_0000_0001, 16'h1234);
		send_request(48'h0000_0000_0001, 16'h1233);

		// Random part. Most requests come from a fixed set of hosts with
		// numbers placed near the last one sent, so that the newer, stale
		// and wraparound decisions are all exercised against a busy table.
		// A few carry a fresh address or one that is a single bit away from
		// a known host, which fills the table early and then hits the full
		// case over and over.
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			calm = (n >= RANDOM_REQUESTS - CALM_REQUESTS);
			pick = $urandom_range(0, 99);
			k = $urandom_range(0, HOSTS - 1);
			seq = 16'($urandom());
			if (pick < 5) begin
				mac = {16'($urandom()), 32'($urandom())};
			end else if (pick < 10) begin
				mac = host_mac[k] ^ (48'd1 << $urandom_range(0, MAC_W - 1));
			end else begin
				mac = host_mac[k];
				case ($urandom_range(0, 7))
					0: delta = 0;
					1: delta = 1;
					2: delta = $urandom_range(2, 300);
					3: delta = -$urandom_range(1, 300);
					4: delta = -WRAP_LIMIT;
					5: delta = -(WRAP_LIMIT - 1);
					6: delta = -(WRAP_LIMIT + 1);
					default: delta = $urandom_range(0, 16'hFFFF);
				endcase
				seq = host_seq[k] + 16'(delta);
				host_seq[k] = seq;
			end
			send_request(mac, seq);
		end
		req_ch.valid <= 1'b0;

		// Let the last request register with the checker, wait for every
		// owed result, then give the table time to show any extra result.
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (failures == 0 && outstanding == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
